/* hw/rtl/clr_pkg.sv */
// shared types and constants for the clipped line rasterizer
`default_nettype none

package clr_pkg;

	localparam int MAX_SCREEN_DIM = 64;
	localparam int COORD_W        = 8;
	localparam int POS_W          = COORD_W + 1;
	localparam int ERR_W          = POS_W + 2;
	localparam int SPAN_W         = POS_W + 1;
	localparam int DIM_W          = 7;
	localparam int PIX_W          = 6;
	localparam int ADDR_W         = 12;
	localparam int COLOR_W        = 32;
	localparam int CFG_INDEX_W    = 2;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_W'(1);

	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_SCREEN_DIM);

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic        [COLOR_W-1:0] line_color;
	} line_cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [ADDR_W-1:0]  pixel_address;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_pixel;
	} pixel_t;

	// setup record handed from the front to the walker
	typedef struct packed {
		logic                    steep;
		logic signed [POS_W-1:0] major_pos;
		logic signed [POS_W-1:0] major_end;
		logic signed [POS_W-1:0] minor_pos;
		logic [SPAN_W-1:0]       error_incr;
		logic [SPAN_W-1:0]       twice_major_span;
		logic                    minor_step_down;
		logic [COLOR_W-1:0]      color;
	} walk_cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} screen_t;

	typedef enum logic [0:0] {
		WALK_IDLE,
		WALK_RUN
	} walk_state_t;

endpackage

`default_nettype wire

/* hw/rtl/clr_front.sv */
// line setup: steepness, endpoint ordering and step constants
`default_nettype none

module clr_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_ready,
	input  clr_pkg::line_cmd_t   cmd,
	output logic                 rec_valid,
	input  wire                  rec_ready,
	output clr_pkg::walk_cmd_t   rec
);
	import clr_pkg::*;

	logic signed [POS_W-1:0] sx, sy, ex, ey;
	logic signed [POS_W-1:0] dx, dy, a0, a1, b0, b1, dmajor, dminor;
	logic [POS_W-1:0]        adx, ady, adminor;
	logic                    steep, swap;
	walk_cmd_t               setup;
	walk_cmd_t               rec_s1;
	logic                    valid_s1;

	always_comb begin
		sx = POS_W'(cmd.start_x);
		sy = POS_W'(cmd.start_y);
		ex = POS_W'(cmd.end_x);
		ey = POS_W'(cmd.end_y);
		dx = ex - sx;
		dy = ey - sy;
		adx = dx[POS_W-1] ? $unsigned(-dx) : $unsigned(dx);
		ady = dy[POS_W-1] ? $unsigned(-dy) : $unsigned(dy);
		steep = adx < ady;
		// transpose steep lines so the walk always runs along the major axis
		a0 = steep ? sy : sx;
		b0 = steep ? sx : sy;
		a1 = steep ? ey : ex;
		b1 = steep ? ex : ey;
		swap = a0 > a1;
		if (swap) begin
			a0 = steep ? ey : ex;
			b0 = steep ? ex : ey;
			a1 = steep ? sy : sx;
			b1 = steep ? sx : sy;
		end
		dmajor = a1 - a0;
		dminor = b1 - b0;
		adminor = dminor[POS_W-1] ? $unsigned(-dminor) : $unsigned(dminor);

		setup.steep            = steep;
		setup.major_pos        = a0;
		setup.major_end        = a1;
		setup.minor_pos        = b0;
		setup.error_incr       = {adminor, 1'b0};
		setup.twice_major_span = {dmajor, 1'b0};
		setup.minor_step_down  = !(b1 > b0);
		setup.color            = cmd.line_color;
	end

	assign cmd_ready = !valid_s1 || rec_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			rec_s1 <= setup;
		end
	end

	assign rec_valid = valid_s1;
	assign rec       = rec_s1;

endmodule

`default_nettype wire

/* hw/rtl/clr_queue.sv */
// small fifo of setup records between front and walker
`default_nettype none

module clr_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	output logic                 push_ready,
	input  clr_pkg::walk_cmd_t   push_data,
	output logic                 pop_valid,
	input  wire                  pop_ready,
	output clr_pkg::walk_cmd_t   pop_data
);
	import clr_pkg::*;

	walk_cmd_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("setup queue count beyond depth");

endmodule

`default_nettype wire

/* hw/rtl/clr_walker.sv */
// bresenham walker with clipping, last-pixel hold and output register
`default_nettype none

module clr_walker (
	input  wire                  clk,
	input  wire                  arst_n,
	input  clr_pkg::screen_t     screen,
	input  wire                  rec_valid,
	output logic                 rec_ready,
	input  clr_pkg::walk_cmd_t   rec,
	output logic                 pix_valid,
	input  wire                  pix_ready,
	output clr_pkg::pixel_t      pix
);
	import clr_pkg::*;

	walk_state_t             state_q, state_d;
	logic                    steep_q, step_down_q;
	logic signed [POS_W-1:0] major_pos_q, major_end_q, minor_pos_q;
	logic [ERR_W-1:0]        error_acc_q;
	logic [SPAN_W-1:0]       error_incr_q, twice_span_q;
	logic [COLOR_W-1:0]      color_q;
	logic                    held_valid_q;
	logic [PIX_W-1:0]        held_x_q, held_y_q;
	logic                    out_valid_q;
	pixel_t                  out_q;

	logic                    done, vis, slot_free;
	logic signed [POS_W-1:0] px, py;
	logic [ERR_W-1:0]        acc_sum, acc_next;
	logic                    pop, step, emit, emit_last;
	logic [ADDR_W+PIX_W-4:0] addr_full;

	always_comb begin
		done = !(major_pos_q < major_end_q);
		px = steep_q ? minor_pos_q : major_pos_q;
		py = steep_q ? major_pos_q : minor_pos_q;
		vis = !px[POS_W-1] && ($unsigned(px) < POS_W'(screen.width))
			&& !py[POS_W-1] && ($unsigned(py) < POS_W'(screen.height));
		slot_free = !out_valid_q || pix_ready;
		acc_sum = error_acc_q + ERR_W'(error_incr_q);
		acc_next = (acc_sum >= ERR_W'(twice_span_q)) ? acc_sum - ERR_W'(twice_span_q) : acc_sum;
		addr_full = (ADDR_W+PIX_W-3)'(held_x_q)
			+ (ADDR_W+PIX_W-3)'(held_y_q) * (ADDR_W+PIX_W-3)'(screen.width);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			WALK_IDLE: begin
				if (rec_valid) state_d = WALK_RUN;
			end
			WALK_RUN: begin
				if (done && (!held_valid_q || slot_free)) state_d = WALK_IDLE;
			end
			default: state_d = WALK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop       = 1'b0;
		step      = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			WALK_IDLE: begin
				pop = rec_valid;
			end
			WALK_RUN: begin
				if (!done) begin
					// a new visible pixel releases the held one, so it needs the slot
					emit = vis && held_valid_q && slot_free;
					step = !(vis && held_valid_q) || slot_free;
				end else begin
					emit      = held_valid_q && slot_free;
					emit_last = emit;
				end
			end
			default: ;
		endcase
	end

	assign rec_ready = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= WALK_IDLE;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				held_valid_q <= 1'b0;
			end else if (step && vis) begin
				held_valid_q <= 1'b1;
			end else if (emit_last) begin
				held_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pix_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			steep_q      <= rec.steep;
			major_pos_q  <= rec.major_pos;
			major_end_q  <= rec.major_end;
			minor_pos_q  <= rec.minor_pos;
			error_acc_q  <= '0;
			error_incr_q <= rec.error_incr;
			twice_span_q <= rec.twice_major_span;
			step_down_q  <= rec.minor_step_down;
			color_q      <= rec.color;
		end else if (step) begin
			if (vis) begin
				held_x_q <= px[PIX_W-1:0];
				held_y_q <= py[PIX_W-1:0];
			end
			error_acc_q <= acc_next;
			if (acc_sum >= ERR_W'(twice_span_q)) begin
				minor_pos_q <= step_down_q ? minor_pos_q - POS_W'(1) : minor_pos_q + POS_W'(1);
			end
			major_pos_q <= major_pos_q + POS_W'(1);
		end
		if (emit) begin
			out_q.pixel_x       <= held_x_q;
			out_q.pixel_y       <= held_y_q;
			out_q.pixel_address <= addr_full[ADDR_W-1:0];
			out_q.pixel_color   <= color_q;
			out_q.last_pixel    <= emit_last;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix       = out_q;

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WALK_RUN && !done) |-> (error_acc_q < ERR_W'(twice_span_q)))
		else $error("error accumulator out of range during walk");

	a_pop_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == WALK_RUN && !held_valid_q))
		else $error("record pop did not start a clean walk");

	a_last_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		emit_last |=> (state_q == WALK_IDLE && !held_valid_q && pix_valid && pix.last_pixel))
		else $error("last pixel left the walker in a bad state");

endmodule

`default_nettype wire

/* hw/rtl/clipped_line_rasterizer.sv */
// top level of the clipped line rasterizer: config registers, front, queue and walker
`default_nettype none

// Clipped Bresenham line rasterizer. Each request on cmd carries two signed
// 8-bit endpoints and a 32-bit color; the block returns, on pix, every pixel
// of the integer Bresenham walk that lies inside the configured screen, with
// its word address x + y * screen_width, and flags the last visible one. The
// endpoint with the larger major-axis coordinate is never drawn, and a line
// that is empty or fully clipped returns nothing. The front registers each
// request and hands a setup record to a two-deep queue, so up to three
// requests can be waiting while one is walked. The walker makes one
// Bresenham step per cycle unless a new visible pixel finds the output
// register full and pix_ready low. For each line it takes the record, walks
// the major span and then releases the held last pixel. At most one pixel
// leaves per cycle. screen_width and screen_height (index 0 and 1 on cfg)
// reset to 64; values above 64 act as 64, and zero hides everything. Write
// them only while the block is idle.

module clipped_line_rasterizer (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [clr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [clr_pkg::DIM_W-1:0]           cfg_data,
	input  wire                                cmd_valid,
	output logic                               cmd_ready,
	input  clr_pkg::line_cmd_t                 cmd,
	output logic                               pix_valid,
	input  wire                                pix_ready,
	output clr_pkg::pixel_t                    pix
);
	import clr_pkg::*;

	logic [DIM_W-1:0] screen_width_q, screen_height_q;
	screen_t          screen;
	logic             front_valid, front_ready;
	walk_cmd_t        front_rec;
	logic             q_valid, q_ready;
	walk_cmd_t        q_rec;

	// config writes are always taken; unknown indexes are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= DIM_MAX;
			screen_height_q <= DIM_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp to the largest supported screen
	always_comb begin
		screen.width  = (screen_width_q > DIM_MAX) ? DIM_MAX : screen_width_q;
		screen.height = (screen_height_q > DIM_MAX) ? DIM_MAX : screen_height_q;
	end

	// front: classify the line and build its walk record
	clr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rec_valid (front_valid),
		.rec_ready (front_ready),
		.rec       (front_rec)
	);

	// decouples setup from the walk so each side stalls on its own
	clr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_rec),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_rec)
	);

	// back: one step per cycle while the output is not blocked, clipping and last-pixel detection
	clr_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.screen    (screen),
		.rec_valid (q_valid),
		.rec_ready (q_ready),
		.rec       (q_rec),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

endmodule

`default_nettype wire

/* bench/clipped_line_rasterizer_checker.sv */
// pixel checker for the clipped line rasterizer: predicts every line and compares the pixels
`timescale 1ns / 1ps

module clipped_line_rasterizer_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_valid,
	input  wire                            cfg_ready,
	input  wire [clr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [clr_pkg::DIM_W-1:0]       cfg_data,
	input  wire                            cmd_valid,
	input  wire                            cmd_ready,
	input  clr_pkg::line_cmd_t             cmd,
	input  wire                            pix_valid,
	input  wire                            pix_ready,
	input  clr_pkg::pixel_t                pix,
	output int                             fail_count,
	output int                             pending,
	output int                             pixels_checked
);
	import clr_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [DIM_W-1:0] scr_width;
	logic [DIM_W-1:0] scr_height;
	pixel_t           pending_pixels[$];
	int               bad_count;
	int               seen_count;

	function automatic int magnitude(int v);
		return (v < 0) ? -v : v;
	endfunction

	// walk one line the way the block does and queue its visible pixels
	function automatic void rasterize_line(line_cmd_t c);
		int     sx, sy, ex, ey;
		int     a0, b0, a1, b1, t;
		int     wd, ht, err, incr, span, minor, px, py;
		logic   steep, down, have_held;
		pixel_t held;
		sx = $signed(c.start_x);
		sy = $signed(c.start_y);
		ex = $signed(c.end_x);
		ey = $signed(c.end_y);
		wd = (scr_width > DIM_MAX) ? MAX_SCREEN_DIM : int'(scr_width);
		ht = (scr_height > DIM_MAX) ? MAX_SCREEN_DIM : int'(scr_height);
		steep = magnitude(ex - sx) < magnitude(ey - sy);
		if (steep) begin
			a0 = sy; b0 = sx; a1 = ey; b1 = ex;
		end else begin
			a0 = sx; b0 = sy; a1 = ex; b1 = ey;
		end
		if (a0 > a1) begin
			t = a0; a0 = a1; a1 = t;
			t = b0; b0 = b1; b1 = t;
		end
		minor = b0;
		err = 0;
		incr = 2 * magnitude(b1 - b0);
		span = 2 * (a1 - a0);
		down = !(b1 > b0);
		have_held = 1'b0;
		held = '0;
		for (int m = a0; m < a1; m++) begin
			px = steep ? minor : m;
			py = steep ? m : minor;
			if (px >= 0 && px < wd && py >= 0 && py < ht) begin
				// a held pixel is only known not to be the last once another shows up
				if (have_held) begin
					pending_pixels.push_back(held);
				end
				have_held = 1'b1;
				held.pixel_x = PIX_W'(px);
				held.pixel_y = PIX_W'(py);
				held.pixel_address = ADDR_W'(px + py * wd);
				held.pixel_color = c.line_color;
				held.last_pixel = 1'b0;
			end
			err += incr;
			if (err >= span) begin
				minor += down ? -1 : 1;
				err -= span;
			end
		end
		if (have_held) begin
			held.last_pixel = 1'b1;
			pending_pixels.push_back(held);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			pending_pixels.delete();
			scr_width = DIM_MAX;
			scr_height = DIM_MAX;
			bad_count = 0;
			seen_count = 0;
			fail_count <= 0;
			pending <= 0;
			pixels_checked <= 0;
		end else begin
			// pixels first, so a pixel with nothing waiting is never paired with a new line
			if (pix_valid && pix_ready) begin
				seen_count++;
				if (pending_pixels.size() == 0) begin
					bad_count++;
					if (bad_count <= REPORT_LIMIT) begin
						$display("pixel %0d not expected: x=%0d y=%0d addr=%0d color=%h last=%0d",
							seen_count, pix.pixel_x, pix.pixel_y, pix.pixel_address,
							pix.pixel_color, pix.last_pixel);
					end
				end else begin
					want = pending_pixels.pop_front();
					if (pix.pixel_x !== want.pixel_x || pix.pixel_y !== want.pixel_y ||
							pix.pixel_address !== want.pixel_address ||
							pix.pixel_color !== want.pixel_color ||
							pix.last_pixel !== want.last_pixel) begin
						bad_count++;
						if (bad_count <= REPORT_LIMIT) begin
							$display("pixel %0d expected x=%0d y=%0d addr=%0d color=%h last=%0d",
								seen_count, want.pixel_x, want.pixel_y, want.pixel_address,
								want.pixel_color, want.last_pixel);
							$display("          got x=%0d y=%0d addr=%0d color=%h last=%0d",
								pix.pixel_x, pix.pixel_y, pix.pixel_address,
								pix.pixel_color, pix.last_pixel);
						end
					end
				end
			end
			if (cmd_valid && cmd_ready) begin
				rasterize_line(cmd);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCREEN_WIDTH: begin
						scr_width = cfg_data;
					end
					REG_SCREEN_HEIGHT: begin
						scr_height = cfg_data;
					end
					default: begin
					end
				endcase
			end
			fail_count <= bad_count;
			pending <= pending_pixels.size();
			pixels_checked <= seen_count;
		end
	end

endmodule

/* bench/clipped_line_rasterizer_tb.sv */
// testbench top for the clipped line rasterizer: line requests, pixel sink stalls and verdict
`timescale 1ns / 1ps

module clipped_line_rasterizer_tb;
	import clr_pkg::*;

	// generous bound, so this only trips on a hang
	localparam int CYCLE_LIMIT  = 1_500_000;
	// up to four lines in flight that may draw nothing
	localparam int DRAIN_CYCLES = 1200;
	localparam int NUM_PHASES   = 9;

	// screen settings per random phase; the last phase picks its own sizes
	localparam int PHASE_W     [NUM_PHASES] = '{64, 1, 127, 0, 64, 13, 40, 64, 0};
	localparam int PHASE_H     [NUM_PHASES] = '{64, 1, 100, 64, 0, 7, 64, 33, 0};
	localparam int PHASE_ITEMS [NUM_PHASES] = '{30, 15, 25, 10, 10, 25, 25, 25, 35};
	// phases with no gaps and no stalls at all
	localparam bit PHASE_CALM  [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 1, 0, 0};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
	logic [DIM_W-1:0]       cfg_data = '0;
	logic                   cmd_valid = 1'b0;
	line_cmd_t              cmd = '0;
	logic                   pix_ready = 1'b0;
	wire                    cfg_ready;
	wire                    cmd_ready;
	wire                    pix_valid;
	pixel_t                 pix;

	int   fail_count;
	int   pending;
	int   pixels_checked;
	int   cycle_count = 0;
	int   lines_sent = 0;
	int   ready_hold = 0;
	logic calm = 1'b0;

	clipped_line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	clipped_line_rasterizer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.pix_valid      (pix_valid),
		.pix_ready      (pix_ready),
		.pix            (pix),
		.fail_count     (fail_count),
		.pending        (pending),
		.pixels_checked (pixels_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			return 0;
		end else if (r < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 20);
	endfunction

	// coordinate around a screen edge of size dim, sometimes anywhere in the 8-bit range
	function automatic int pick_coord(int dim);
		int r;
		int v;
		r = $urandom_range(0, 19);
		if (r < 12) begin
			v = int'($urandom_range(0, dim + 16)) - 8;
		end else if (r < 16) begin
			v = int'($signed(8'($urandom_range(0, 255))));
		end else begin
			case ($urandom_range(0, 3))
				0: v = -128;
				1: v = 127;
				2: v = dim - 1;
				default: v = dim;
			endcase
		end
		return v;
	endfunction

	// pixel sink: runs of ready broken by stalls of random length
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (calm || $urandom_range(0, 3) != 0) begin
			pix_ready <= 1'b1;
			ready_hold <= $urandom_range(0, 6);
		end else begin
			pix_ready <= 1'b0;
			ready_hold <= idle_span();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels still expected", cycle_count, pending);
			$display("clipped_line_rasterizer_tb NOT OK");
			$finish;
		end
	end

	// one line request; valid stays high afterwards so back-to-back requests keep it up
	task automatic send_line(int sx, int sy, int ex, int ey, logic [COLOR_W-1:0] color);
		int gap;
		gap = calm ? 0 : idle_span();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{start_x: 8'(sx), start_y: 8'(sy), end_x: 8'(ex), end_y: 8'(ey),
			line_color: color};
		do @(posedge clk); while (!cmd_ready);
		lines_sent++;
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(value);
		do @(posedge clk); while (!cfg_ready);
	endtask

	// wait out every expected pixel, then long enough for lines that draw nothing
	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int w, h, dim_x, dim_y, sx, sy, ex, ey;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines on the reset screen of 64 by 64
		send_line(0, 0, 63, 0, 32'h0000_0000);        // flat, whole row but the excluded end
		send_line(63, 5, 0, 5, 32'hffff_ffff);        // flat, endpoints reversed
		send_line(10, 0, 10, 63, 32'haaaa_aaaa);      // vertical, steep
		send_line(10, 63, 10, 0, 32'h5555_5555);      // vertical, reversed
		send_line(0, 0, 63, 63, 32'h1234_5678);       // diagonal is not steep
		send_line(63, 0, 0, 63, 32'h8765_4321);       // anti-diagonal, minor steps down
		send_line(5, 5, 5, 5, 32'hdead_beef);         // equal endpoints, nothing drawn
		send_line(-128, -128, 127, 127, 32'hffff_ffff);
		send_line(127, -128, -128, 127, 32'h0f0f_0f0f);
		send_line(-128, 127, 127, -128, 32'hf0f0_f0f0);
		send_line(-128, 0, 127, 0, 32'h0000_0001);     // both ends clipped
		send_line(0, -128, 0, 127, 32'h8000_0000);
		send_line(-100, -50, -10, -20, 32'h0bad_cafe); // fully off screen to the left
		send_line(70, 10, 120, 60, 32'h0bad_f00d);     // fully off screen to the right
		send_line(-20, 30, 80, 40, 32'h1357_9bdf);     // clipped on both sides
		send_line(7, -5, 7, 70, 32'h2468_ace0);        // steep with no minor movement
		send_line(0, 0, 60, 7, 32'h3c3c_3c3c);         // shallow slope
		send_line(2, 1, 9, 60, 32'hc3c3_c3c3);         // steep slope
		send_line(4, 4, 5, 4, 32'h7777_7777);          // single pixel
		send_line(5, 5, 4, 4, 32'h8888_8888);          // single pixel, reordered
		send_line(-1, -1, 0, 0, 32'h9999_9999);        // only the excluded end is visible
		send_line(63, 63, 64, 64, 32'h6666_6666);      // single corner pixel
		send_line(0, 63, 63, -1, 32'h0102_0304);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			w = (p == NUM_PHASES - 1) ? $urandom_range(1, 64) : PHASE_W[p];
			h = (p == NUM_PHASES - 1) ? $urandom_range(1, 64) : PHASE_H[p];
			write_reg(REG_SCREEN_WIDTH, w);
			write_reg(REG_SCREEN_HEIGHT, h);
			cfg_valid <= 1'b0;
			calm <= PHASE_CALM[p];
			// oversize acts as 64; a zero size still gets lines near the origin
			dim_x = (w > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : ((w == 0) ? 16 : w);
			dim_y = (h > MAX_SCREEN_DIM) ? MAX_SCREEN_DIM : ((h == 0) ? 16 : h);
			for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
				sx = pick_coord(dim_x);
				sy = pick_coord(dim_y);
				if ($urandom_range(0, 4) == 0) begin
					// short line close to its start
					ex = sx + int'($urandom_range(0, 6)) - 3;
					ey = sy + int'($urandom_range(0, 6)) - 3;
				end else begin
					ex = pick_coord(dim_x);
					ey = pick_coord(dim_y);
				end
				send_line(sx, sy, ex, ey, $urandom());
			end
			settle();
		end

		$display("%0d line requests over %0d screen settings, %0d pixels checked",
			lines_sent, NUM_PHASES + 1, pixels_checked);
		$display("covered clipping on all sides, empty lines, oversize and zero screens");
		if (fail_count == 0 && pending == 0) begin
			$display("clipped_line_rasterizer_tb OK");
		end else begin
			$display("clipped_line_rasterizer_tb NOT OK");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/clr_pkg.sv
hw/rtl/clr_front.sv
hw/rtl/clr_queue.sv
hw/rtl/clr_walker.sv
hw/rtl/clipped_line_rasterizer.sv
bench/clipped_line_rasterizer_checker.sv
bench/clipped_line_rasterizer_tb.sv
